>>> hw/rtl/i2cte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cte_pkg;

    localparam int ADDR_W  = 7;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int CFG_W   = 7;

    localparam logic [COUNT_W-1:0] ADDR_BITS  = COUNT_W'(9);
    localparam logic [COUNT_W-1:0] BYTE_BITS  = COUNT_W'(8);

    typedef enum logic [0:0] {
        CFG_TARGET_ADDRESS = 1'b0,
        CFG_TARGET_ENABLE  = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              sda_out;
        logic [BYTE_W-1:0] data_byte;
        logic              address_strobe;
        logic              address_matched;
        logic              write_strobe;
        logic              fetch_strobe;
        logic              master_ack_strobe;
        logic              master_nack;
        logic              start_seen;
        logic              stop_seen;
    } t_result;

    typedef struct packed {
        logic              sda_in;
        logic              scl_in;
        logic [BYTE_W-1:0] read_data;
        logic              write_nack;
    } t_sample;

endpackage

`default_nettype wire

>>> hw/rtl/i2cte_core.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cte_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_fire,
    input  wire i2cte_pkg::t_sample             i_sample,
    input  wire logic [i2cte_pkg::ADDR_W-1:0]   i_target_address,
    input  wire logic                           i_target_enable,
    output i2cte_pkg::t_result                  o_result
);
    import i2cte_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ADDR      = 3'd1,
        PH_ADDR_ACK  = 3'd2,
        PH_WRITE     = 3'd3,
        PH_WRITE_ACK = 3'd4,
        PH_READ      = 3'd5,
        PH_READ_ACK  = 3'd6
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_prev_sda, r_prev_scl;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_drive, n_drive;
    logic                r_read_mode, n_read_mode;

    logic                sda, scl;
    logic [COUNT_W-1:0]  count_inc;
    logic [BYTE_W-1:0]   shift_in;
    logic [BYTE_W-1:0]   shift_out;
    t_result             res;

    always_comb begin
        sda       = i_sample.sda_in;
        scl       = i_sample.scl_in;
        count_inc = r_count + COUNT_W'(1);
        shift_in  = {r_shift[BYTE_W-2:0], sda};
        shift_out = {r_shift[BYTE_W-2:0], 1'b0};

        n_phase     = r_phase;
        n_shift     = r_shift;
        n_count     = r_count;
        n_drive     = r_drive;
        n_read_mode = r_read_mode;
        res         = '0;

        if (r_prev_scl && scl && r_prev_sda && !sda) begin
            res.start_seen = 1'b1;
            n_phase        = PH_ADDR;
            n_shift        = '0;
            n_count        = '0;
            n_drive        = 1'b1;
        end
        if (r_prev_scl && scl && !r_prev_sda && sda) begin
            res.stop_seen = 1'b1;
            n_phase       = PH_IDLE;
            n_drive       = 1'b1;
        end

        if (r_prev_scl && !scl) begin
            case (r_phase)
                PH_ADDR: begin
                    n_shift = shift_in;
                    n_count = count_inc;
                    if (count_inc >= ADDR_BITS) begin
                        res.address_strobe = 1'b1;
                        res.data_byte      = shift_in;
                        if (i_target_enable && shift_in[BYTE_W-1:1] == i_target_address) begin
                            res.address_matched = 1'b1;
                            n_drive             = 1'b0;
                            n_read_mode         = shift_in[0];
                            n_phase             = PH_ADDR_ACK;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_ADDR_ACK: begin
                    n_count = '0;
                    if (!r_read_mode) begin
                        n_phase = PH_WRITE;
                        n_shift = '0;
                        n_drive = 1'b1;
                    end else begin
                        n_phase            = PH_READ;
                        n_shift            = i_sample.read_data;
                        res.fetch_strobe   = 1'b1;
                        n_drive            = i_sample.read_data[BYTE_W-1];
                    end
                end
                PH_WRITE: begin
                    n_shift = shift_in;
                    n_count = count_inc;
                    if (count_inc >= BYTE_BITS) begin
                        res.write_strobe = 1'b1;
                        res.data_byte    = shift_in;
                        n_drive          = i_sample.write_nack;
                        n_phase          = PH_WRITE_ACK;
                    end
                end
                PH_WRITE_ACK: begin
                    if (!r_drive) begin
                        n_phase = PH_WRITE;
                        n_shift = '0;
                        n_count = '0;
                        n_drive = 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                PH_READ: begin
                    n_shift = shift_out;
                    n_drive = shift_out[BYTE_W-1];
                    n_count = count_inc;
                    if (count_inc >= BYTE_BITS) begin
                        n_drive = 1'b1;
                        n_phase = PH_READ_ACK;
                    end
                end
                PH_READ_ACK: begin
                    res.master_ack_strobe = 1'b1;
                    res.master_nack       = sda;
                    if (!sda) begin
                        n_shift          = i_sample.read_data;
                        res.fetch_strobe = 1'b1;
                        n_count          = '0;
                        n_drive          = i_sample.read_data[BYTE_W-1];
                        n_phase          = PH_READ;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end

        res.sda_out = sda & n_drive;
        o_result    = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_prev_sda  <= 1'b0;
            r_prev_scl  <= 1'b0;
            r_shift     <= '0;
            r_count     <= '0;
            r_drive     <= 1'b1;
            r_read_mode <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_prev_sda  <= sda;
            r_prev_scl  <= scl;
            r_shift     <= n_shift;
            r_count     <= n_count;
            r_drive     <= n_drive;
            r_read_mode <= n_read_mode;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cte_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module i2cte_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire i2cte_pkg::t_result i_result,
    output logic                    o_space,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output i2cte_pkg::t_result      o_result
);
    import i2cte_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;

        if (r_main_valid && i_ready) begin
            n_main_valid = 1'b0;
        end
        if (r_skid_valid && !n_main_valid) begin
            n_main       = r_skid;
            n_main_valid = 1'b1;
            n_skid_valid = 1'b0;
        end
        if (i_push) begin
            if (!n_main_valid) begin
                n_main       = i_result;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_space  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

`default_nettype wire

>>> hw/rtl/i2c_target_bit_engine.sv
// I2C target bit engine. Each accepted input transfer is one sample of SDA and SCL
// and yields exactly one result transfer: the resolved SDA level plus event strobes
// (START, STOP, address byte, write byte, read fetch, controller ack). One sample
// is taken per clock while input ready is high; each result is registered in a
// two-entry output buffer behind the line-state logic, so input ready falls
// only once two results wait downstream. Set target_address and target_enable
// through the write port while no transfer is in flight.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_bit_engine (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [i2cte_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_sda_in,
    input  wire logic                          i_scl_in,
    input  wire logic [i2cte_pkg::BYTE_W-1:0]  i_read_data,
    input  wire logic                          i_write_nack,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic                               o_sda_out,
    output logic [i2cte_pkg::BYTE_W-1:0]       o_data_byte,
    output logic                               o_address_strobe,
    output logic                               o_address_matched,
    output logic                               o_write_strobe,
    output logic                               o_fetch_strobe,
    output logic                               o_master_ack_strobe,
    output logic                               o_master_nack,
    output logic                               o_start_seen,
    output logic                               o_stop_seen
);
    import i2cte_pkg::*;

    logic [ADDR_W-1:0] r_target_address;
    logic              r_target_enable;
    logic              space;
    logic              fire;
    t_sample           sample;
    t_result           step_result;
    t_result           out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_address <= '0;
            r_target_enable  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_TARGET_ADDRESS: r_target_address <= i_cfg_data[ADDR_W-1:0];
                CFG_TARGET_ENABLE:  r_target_enable  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = space;
    assign fire       = i_in_valid && space;

    always_comb begin
        sample.sda_in     = i_sda_in;
        sample.scl_in     = i_scl_in;
        sample.read_data  = i_read_data;
        sample.write_nack = i_write_nack;
    end

    i2cte_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (fire),
        .i_sample         (sample),
        .i_target_address (r_target_address),
        .i_target_enable  (r_target_enable),
        .o_result         (step_result)
    );

    i2cte_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fire),
        .i_result (step_result),
        .o_space  (space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_sda_out           = out_result.sda_out;
    assign o_data_byte         = out_result.data_byte;
    assign o_address_strobe    = out_result.address_strobe;
    assign o_address_matched   = out_result.address_matched;
    assign o_write_strobe      = out_result.write_strobe;
    assign o_fetch_strobe      = out_result.fetch_strobe;
    assign o_master_ack_strobe = out_result.master_ack_strobe;
    assign o_master_nack       = out_result.master_nack;
    assign o_start_seen        = out_result.start_seen;
    assign o_stop_seen         = out_result.stop_seen;

endmodule

`default_nettype wire

>>> sim/tb_i2c_target_bit_engine.sv
`timescale 1ns / 1ps

module tb_i2c_target_bit_engine;
    import i2cte_pkg::*;

    typedef enum logic [2:0] {
        BUS_IDLE,
        BUS_ADDR,
        BUS_ADDR_ACK,
        BUS_WRITE,
        BUS_WRITE_ACK,
        BUS_READ,
        BUS_READ_ACK
    } t_bus_phase;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_sda_in = 1'b1;
    logic              i_scl_in = 1'b1;
    logic [BYTE_W-1:0] i_read_data = '0;
    logic              i_write_nack = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_sda_out;
    logic [BYTE_W-1:0] o_data_byte;
    logic              o_address_strobe;
    logic              o_address_matched;
    logic              o_write_strobe;
    logic              o_fetch_strobe;
    logic              o_master_ack_strobe;
    logic              o_master_nack;
    logic              o_start_seen;
    logic              o_stop_seen;

    i2c_target_bit_engine uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_sda_in            (i_sda_in),
        .i_scl_in            (i_scl_in),
        .i_read_data         (i_read_data),
        .i_write_nack        (i_write_nack),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_sda_out           (o_sda_out),
        .o_data_byte         (o_data_byte),
        .o_address_strobe    (o_address_strobe),
        .o_address_matched   (o_address_matched),
        .o_write_strobe      (o_write_strobe),
        .o_fetch_strobe      (o_fetch_strobe),
        .o_master_ack_strobe (o_master_ack_strobe),
        .o_master_nack       (o_master_nack),
        .o_start_seen        (o_start_seen),
        .o_stop_seen         (o_stop_seen)
    );

    // line samples waiting to be sent, and results they must produce
    t_sample line_samples[$];
    t_result expected_lines[$];

    // target model state
    logic [ADDR_W-1:0]  cfg_address = '0;
    logic               cfg_enable = 1'b0;
    logic               bus_sda_q = 1'b0;
    logic               bus_scl_q = 1'b0;
    t_bus_phase         bus_phase = BUS_IDLE;
    logic [BYTE_W-1:0]  shift_q = '0;
    logic [COUNT_W-1:0] bits_q = '0;
    logic               drive_q = 1'b1;
    logic               read_dir = 1'b0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int wnack_pct = 10;
    int queued = 0;
    int error_count = 0;
    int results_seen = 0;
    int addr_hits = 0;
    int write_bytes = 0;
    int fetches = 0;
    int ctrl_acks = 0;
    int starts = 0;
    int stops = 0;
    logic in_taken = 1'b0;

    function automatic t_result line_step(input t_sample s);
        t_result r;
        logic    was_sda;
        logic    was_scl;
        r = '0;
        was_sda = bus_sda_q;
        was_scl = bus_scl_q;
        bus_sda_q = s.sda_in;
        bus_scl_q = s.scl_in;
        if (was_scl && s.scl_in) begin
            if (was_sda && !s.sda_in) begin
                r.start_seen = 1'b1;
                bus_phase = BUS_ADDR;
                shift_q = '0;
                bits_q = '0;
                drive_q = 1'b1;
            end
            if (!was_sda && s.sda_in) begin
                r.stop_seen = 1'b1;
                bus_phase = BUS_IDLE;
                drive_q = 1'b1;
            end
        end
        if (was_scl && !s.scl_in) begin
            case (bus_phase)
                BUS_ADDR: begin
                    shift_q = {shift_q[BYTE_W-2:0], s.sda_in};
                    bits_q = bits_q + 1'b1;
                    if (bits_q >= ADDR_BITS) begin
                        r.address_strobe = 1'b1;
                        r.data_byte = shift_q;
                        if (cfg_enable && shift_q[BYTE_W-1:1] == cfg_address) begin
                            r.address_matched = 1'b1;
                            drive_q = 1'b0;
                            read_dir = shift_q[0];
                            bus_phase = BUS_ADDR_ACK;
                        end else begin
                            bus_phase = BUS_IDLE;
                        end
                    end
                end
                BUS_ADDR_ACK: begin
                    bits_q = '0;
                    if (!read_dir) begin
                        bus_phase = BUS_WRITE;
                        shift_q = '0;
                        drive_q = 1'b1;
                    end else begin
                        bus_phase = BUS_READ;
                        shift_q = s.read_data;
                        r.fetch_strobe = 1'b1;
                        drive_q = shift_q[BYTE_W-1];
                    end
                end
                BUS_WRITE: begin
                    shift_q = {shift_q[BYTE_W-2:0], s.sda_in};
                    bits_q = bits_q + 1'b1;
                    if (bits_q >= BYTE_BITS) begin
                        r.write_strobe = 1'b1;
                        r.data_byte = shift_q;
                        drive_q = s.write_nack;
                        bus_phase = BUS_WRITE_ACK;
                    end
                end
                BUS_WRITE_ACK: begin
                    if (!drive_q) begin
                        bus_phase = BUS_WRITE;
                        shift_q = '0;
                        bits_q = '0;
                        drive_q = 1'b1;
                    end else begin
                        bus_phase = BUS_IDLE;
                    end
                end
                BUS_READ: begin
                    shift_q = {shift_q[BYTE_W-2:0], 1'b0};
                    drive_q = shift_q[BYTE_W-1];
                    bits_q = bits_q + 1'b1;
                    if (bits_q >= BYTE_BITS) begin
                        drive_q = 1'b1;
                        bus_phase = BUS_READ_ACK;
                    end
                end
                BUS_READ_ACK: begin
                    r.master_ack_strobe = 1'b1;
                    r.master_nack = s.sda_in;
                    if (!s.sda_in) begin
                        shift_q = s.read_data;
                        r.fetch_strobe = 1'b1;
                        bits_q = '0;
                        drive_q = shift_q[BYTE_W-1];
                        bus_phase = BUS_READ;
                    end else begin
                        bus_phase = BUS_IDLE;
                    end
                end
                default: begin
                end
            endcase
        end
        r.sda_out = s.sda_in & drive_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    task automatic queue_sample(input logic sda, input logic scl);
        t_sample s;
        s.sda_in = sda;
        s.scl_in = scl;
        case ($urandom_range(0, 3))
            0:       s.read_data = '0;
            1:       s.read_data = '1;
            default: s.read_data = BYTE_W'($urandom);
        endcase
        s.write_nack = ($urandom_range(0, 99) < wnack_pct);
        line_samples.push_back(s);
        queued++;
    endtask

    task automatic send_bit(input logic b);
        if ($urandom_range(0, 3) == 0) begin
            queue_sample(b, 1'b0);
        end
        queue_sample(b, 1'b1);
        if ($urandom_range(0, 3) == 0) begin
            queue_sample(b, 1'b1);
        end
        queue_sample(b, 1'b0);
    endtask

    task automatic line_noise(input int n);
        for (int i = 0; i < n; i++) begin
            queue_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // START, address byte, ack slot, then data bytes with their ack slots and an optional STOP;
    // cut truncates the bit slots to model an aborted transfer
    task automatic run_transfer(input logic [ADDR_W-1:0] addr, input logic rw,
                                input int nbytes, input int cut, input logic end_stop);
        logic              slots[$];
        logic [BYTE_W-1:0] addr_byte;
        logic [BYTE_W-1:0] b;
        addr_byte = {addr, rw};
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            slots.push_back(addr_byte[i]);
        end
        slots.push_back(1'b1);
        for (int k = 0; k < nbytes; k++) begin
            b = BYTE_W'($urandom);
            for (int i = BYTE_W - 1; i >= 0; i--) begin
                slots.push_back(rw ? 1'b1 : b[i]);
            end
            slots.push_back(rw ? (k == nbytes - 1) : 1'b1);
        end
        queue_sample(1'b1, 1'b0);
        queue_sample(1'b1, 1'b1);
        queue_sample(1'b0, 1'b1);
        queue_sample(1'b0, 1'b0);
        for (int i = 0; i < slots.size() && i < cut; i++) begin
            send_bit(slots[i]);
        end
        if (end_stop) begin
            queue_sample(1'b0, 1'b0);
            queue_sample(1'b0, 1'b1);
            queue_sample(1'b1, 1'b1);
        end
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        if (idx == CFG_TARGET_ADDRESS) begin
            cfg_address = val[ADDR_W-1:0];
        end else begin
            cfg_enable = val[0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pacing(input int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    task automatic wait_drained();
        while (line_samples.size() != 0 || i_in_valid || expected_lines.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // driver: new line sample once the previous transfer has gone
    always @(negedge i_clk) begin
        t_sample cur;
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (line_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur = line_samples.pop_front();
                    i_sda_in <= cur.sda_in;
                    i_scl_in <= cur.scl_in;
                    i_read_data <= cur.read_data;
                    i_write_nack <= cur.write_nack;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: predict on input transfer, then check output transfer
    always @(posedge i_clk) begin
        t_sample s;
        t_result want;
        in_taken = i_rst_n && i_in_valid && o_in_ready;
        if (in_taken) begin
            s.sda_in = i_sda_in;
            s.scl_in = i_scl_in;
            s.read_data = i_read_data;
            s.write_nack = i_write_nack;
            expected_lines.push_back(line_step(s));
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_lines.size() == 0) begin
                $error("result transfer with nothing expected");
                error_count++;
            end else begin
                want = expected_lines.pop_front();
                results_seen++;
                addr_hits += int'(want.address_matched);
                write_bytes += int'(want.write_strobe);
                fetches += int'(want.fetch_strobe);
                ctrl_acks += int'(want.master_ack_strobe);
                starts += int'(want.start_seen);
                stops += int'(want.stop_seen);
                check_field("sda_out", BYTE_W'(want.sda_out), BYTE_W'(o_sda_out));
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("address_strobe", BYTE_W'(want.address_strobe),
                            BYTE_W'(o_address_strobe));
                check_field("address_matched", BYTE_W'(want.address_matched),
                            BYTE_W'(o_address_matched));
                check_field("write_strobe", BYTE_W'(want.write_strobe),
                            BYTE_W'(o_write_strobe));
                check_field("fetch_strobe", BYTE_W'(want.fetch_strobe),
                            BYTE_W'(o_fetch_strobe));
                check_field("master_ack_strobe", BYTE_W'(want.master_ack_strobe),
                            BYTE_W'(o_master_ack_strobe));
                check_field("master_nack", BYTE_W'(want.master_nack),
                            BYTE_W'(o_master_nack));
                check_field("start_seen", BYTE_W'(want.start_seen), BYTE_W'(o_start_seen));
                check_field("stop_seen", BYTE_W'(want.stop_seen), BYTE_W'(o_stop_seen));
            end
        end
    end

    initial begin
        int goal;
        logic [ADDR_W-1:0] a;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: writes with ack and nack, reads ending in nack,
        // a foreign address, a repeated START mid-read, line noise
        write_reg(CFG_TARGET_ADDRESS, CFG_W'(127));
        write_reg(CFG_TARGET_ENABLE, CFG_W'(1));
        set_pacing(0);
        @(posedge i_clk);
        wnack_pct = 0;
        run_transfer(7'd127, 1'b0, 2, 1000, 1'b1);
        wnack_pct = 100;
        run_transfer(7'd127, 1'b0, 1, 1000, 1'b1);
        wnack_pct = 0;
        run_transfer(7'd127, 1'b1, 2, 1000, 1'b1);
        run_transfer(7'd0, 1'b0, 1, 1000, 1'b1);
        run_transfer(7'd127, 1'b1, 1, 13, 1'b0);
        run_transfer(7'd127, 1'b0, 1, 1000, 1'b1);
        line_noise(12);
        wnack_pct = 10;
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       a = '0;
                1:       a = '1;
                default: a = ADDR_W'($urandom_range(0, 127));
            endcase
            write_reg(CFG_TARGET_ADDRESS, CFG_W'(a));
            write_reg(CFG_TARGET_ENABLE, CFG_W'((p == 3 || p == 6) ? 0 : 1));
            set_pacing(p % 4);
            @(posedge i_clk);
            goal = queued + 24;
            while (queued < goal) begin
                if ($urandom_range(0, 99) < 10) begin
                    line_noise($urandom_range(2, 12));
                end else begin
                    run_transfer(($urandom_range(0, 3) != 0) ? cfg_address
                                                             : ADDR_W'($urandom_range(0, 127)),
                                 1'($urandom_range(0, 1)), $urandom_range(1, 3),
                                 ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : 1000,
                                 ($urandom_range(0, 4) != 0));
                end
            end
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        $display("ran %0d line samples, checked %0d results over 9 address/enable settings",
                 queued, results_seen);
        $display("saw %0d STARTs, %0d STOPs, %0d address hits, %0d write bytes,",
                 starts, stops, addr_hits, write_bytes);
        $display("    %0d fetches, %0d controller acks", fetches, ctrl_acks);
        if (error_count == 0) begin
            $display("tb_i2c_target_bit_engine: done, clean");
        end else begin
            $display("tb_i2c_target_bit_engine: done, errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("tb_i2c_target_bit_engine: done, errors");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/i2cte_pkg.sv
hw/rtl/i2cte_core.sv
hw/rtl/i2cte_out_buf.sv
hw/rtl/i2c_target_bit_engine.sv
sim/tb_i2c_target_bit_engine.sv
